// ----- rtl/dtc_pkg.sv -----
// dtc_pkg: shared types, widths, constants and small tables for the distance trend classifier
// no dependencies; imported by every rtl module of the block
`default_nettype none

package dtc_pkg;

    // history length limit, 3..15
    localparam int MAX_SAMPLES = 10;

    localparam int CNT_W    = 4;
    localparam int DIST_W   = 16;
    localparam int FRAME_W  = 16;
    localparam int SUM_D_W  = 20;
    localparam int SUM_KD_W = 24;
    localparam int SUM_DD_W = 36;
    localparam int SK_W     = 7;
    localparam int SKK_W    = 13;
    localparam int SXY_W    = 28;
    localparam int MAG_W    = SXY_W - 1;
    localparam int SQ_W     = 40;
    localparam int SYY_W    = SQ_W + 1;
    localparam int DEN_W    = SKK_W + FRAME_W;
    localparam int RATE_W   = 8;
    localparam int NUM_W    = MAG_W + RATE_W;
    localparam int THR_W    = 16;
    localparam int CTHR_W   = 15;
    localparam int LIM_W    = THR_W + DEN_W;
    localparam int PROD_W   = 52;
    localparam int ROOT_W   = PROD_W / 2;
    localparam int DVD_W    = 42;
    localparam int DVS_W    = DEN_W;
    localparam int OUT_W    = 16;
    localparam int CORR_SH  = 15;
    localparam int SLOPE_SH = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [THR_W-1:0]  SLOPE_THR_RST  = 16'd1920;
    localparam logic [CTHR_W-1:0] CORR_THR_RST   = 15'd21299;
    localparam logic [RATE_W-1:0] FRAME_RATE_RST = 8'd30;
    localparam logic [OUT_W-1:0]  SLOPE_ONE      = 16'd256;

    typedef enum logic [1:0] {
        MS_NOT_MOVE     = 2'd0,
        MS_CLOSING      = 2'd1,
        MS_FAR_AWAY     = 2'd2,
        MS_NOT_ASSESSED = 2'd3
    } move_state_t;

    typedef enum logic [1:0] {
        CFG_SLOPE_THR  = 2'd0,
        CFG_CORR_THR   = 2'd1,
        CFG_FRAME_RATE = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        B_IDLE, B_MUL0, B_MUL1, B_MUL2, B_MUL3, B_DIVS, B_SQRT, B_DIVC, B_FIN
    } back_state_t;

    typedef struct packed {
        logic [THR_W-1:0]  slope_thr;
        logic [CTHR_W-1:0] corr_thr;
        logic [RATE_W-1:0] frame_rate;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]    n;
        logic [SUM_D_W-1:0]  sum_d;
        logic [SUM_KD_W-1:0] sum_kd;
        logic [SUM_DD_W-1:0] sum_dd;
        logic [FRAME_W-1:0]  gap;
    } job_t;

    // n(n-1)/2
    function automatic logic [SK_W-1:0] sk_of(input logic [CNT_W-1:0] n);
        logic [2*CNT_W-1:0] p;
        p = n * (n - CNT_W'(1));
        return SK_W'(p >> 1);
    endfunction

    // n*sum(k^2) - sk^2 = n^2(n^2-1)/12
    function automatic logic [SKK_W-1:0] skk_of(input logic [CNT_W-1:0] n);
        logic [SKK_W-1:0] v;
        case (n)
            4'd2:    v = 13'd1;
            4'd3:    v = 13'd6;
            4'd4:    v = 13'd20;
            4'd5:    v = 13'd50;
            4'd6:    v = 13'd105;
            4'd7:    v = 13'd196;
            4'd8:    v = 13'd336;
            4'd9:    v = 13'd540;
            4'd10:   v = 13'd825;
            4'd11:   v = 13'd1210;
            4'd12:   v = 13'd1716;
            4'd13:   v = 13'd2366;
            4'd14:   v = 13'd3185;
            4'd15:   v = 13'd4200;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    // truncated magnitude plus sign to saturated signed 16 bit
    function automatic logic [OUT_W-1:0] sat16(input logic [DVD_W-1:0] q, input logic neg);
        logic [OUT_W-1:0] v;
        if (!neg)
            v = (q > DVD_W'(32767)) ? 16'h7FFF : q[OUT_W-1:0];
        else
            v = (q > DVD_W'(32768)) ? 16'h8000 : OUT_W'(~q[OUT_W-1:0] + OUT_W'(1));
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dtc_if.sv -----
// dtc_if: valid/ready channel interfaces for samples, results and register writes
// depends on dtc_pkg for field widths
`default_nettype none

interface dtc_sample_if;
    import dtc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [DIST_W-1:0]    distance;
    logic [FRAME_W-1:0]   frame_num;
    logic                 last_sample;
    modport source (output valid, distance, frame_num, last_sample, input ready);
    modport sink   (input valid, distance, frame_num, last_sample, output ready);
endinterface

interface dtc_result_if;
    import dtc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               move_state;
    logic signed [OUT_W-1:0]  slope;
    logic signed [OUT_W-1:0]  correlation;
    modport source (output valid, move_state, slope, correlation, input ready);
    modport sink   (input valid, move_state, slope, correlation, output ready);
endinterface

interface dtc_cfg_if;
    import dtc_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [THR_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtc_front.sv -----
// dtc_front: accepts samples and keeps the running sums of one history
// depends on dtc_pkg and dtc_if; hands finished histories to dtc_queue
`default_nettype none

module dtc_front
    import dtc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dtc_sample_if.sink    samp,
    input  logic          q_full,
    output logic          push,
    output job_t          push_job
);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_D_W-1:0]  sum_d_reg, sum_d_next;
    logic [SUM_KD_W-1:0] sum_kd_reg, sum_kd_next;
    logic [SUM_DD_W-1:0] sum_dd_reg, sum_dd_next;
    logic [FRAME_W-1:0]  first_reg, first_next;
    logic [FRAME_W-1:0]  gap_reg, gap_next;

    logic                accept;
    logic                counting;
    logic [2*DIST_W-1:0] dd;
    logic [SUM_D_W-1:0]  kd;
    job_t                upd;

    assign samp.ready = !q_full;
    assign accept     = samp.valid && samp.ready;
    assign counting   = count_reg < CNT_W'(MAX_SAMPLES);
    assign dd         = samp.distance * samp.distance;
    assign kd         = count_reg * samp.distance;

    // sums including the current sample
    always_comb
    begin
        upd.n      = count_reg;
        upd.sum_d  = sum_d_reg;
        upd.sum_kd = sum_kd_reg;
        upd.sum_dd = sum_dd_reg;
        upd.gap    = gap_reg;
        first_next = first_reg;
        if (counting)
        begin
            upd.n      = count_reg + CNT_W'(1);
            upd.sum_d  = sum_d_reg + SUM_D_W'(samp.distance);
            upd.sum_kd = sum_kd_reg + SUM_KD_W'(kd);
            upd.sum_dd = sum_dd_reg + SUM_DD_W'(dd);
            if (count_reg == CNT_W'(0))
                first_next = samp.frame_num;
            else if (count_reg == CNT_W'(1))
                upd.gap = samp.frame_num - first_reg;
        end
    end

    assign push     = accept && samp.last_sample;
    assign push_job = upd;

    always_comb
    begin
        count_next  = count_reg;
        sum_d_next  = sum_d_reg;
        sum_kd_next = sum_kd_reg;
        sum_dd_next = sum_dd_reg;
        gap_next    = gap_reg;
        if (accept)
        begin
            if (samp.last_sample)
            begin
                count_next  = '0;
                sum_d_next  = '0;
                sum_kd_next = '0;
                sum_dd_next = '0;
                gap_next    = '0;
            end
            else
            begin
                count_next  = upd.n;
                sum_d_next  = upd.sum_d;
                sum_kd_next = upd.sum_kd;
                sum_dd_next = upd.sum_dd;
                gap_next    = upd.gap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_d_reg  <= '0;
            sum_kd_reg <= '0;
            sum_dd_reg <= '0;
            first_reg  <= '0;
            gap_reg    <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            sum_d_reg  <= sum_d_next;
            sum_kd_reg <= sum_kd_next;
            sum_dd_reg <= sum_dd_next;
            if (accept)
                first_reg <= first_next;
            gap_reg    <= gap_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dtc_queue.sv -----
// dtc_queue: short queue of finished histories between front and back
// depends on dtc_pkg
`default_nettype none

module dtc_queue
    import dtc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  job_t  push_job,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output job_t  pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push, do_pop;

    assign full      = level_reg == LVL_W'(QUEUE_DEPTH);
    assign pop_valid = level_reg != '0;
    assign pop_job   = entry_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        level_next = level_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (do_push && !do_pop)
            level_next = level_reg + LVL_W'(1);
        else if (do_pop && !do_push)
            level_next = level_reg - LVL_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dtc_sqrt.sv -----
// dtc_sqrt: iterative floor square root, one result bit per cycle
// depends on dtc_pkg
`default_nettype none

module dtc_sqrt
    import dtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam logic [PROD_W-1:0] BIT_TOP = PROD_W'(1) << (PROD_W - 2);

    logic [PROD_W-1:0] v_reg, v_next, r_reg, r_next, bit_reg, bit_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [PROD_W:0]   trial;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = radicand;
            r_next    = '0;
            bit_next  = BIT_TOP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next = v_reg - trial[PROD_W-1:0];
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
                r_next = r_reg >> 1;
            bit_next = bit_reg >> 2;
            if (bit_reg == PROD_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/dtc_div.sv -----
// dtc_div: restoring unsigned divider, one quotient bit per cycle
// depends on dtc_pkg; shared by the slope and correlation quotients
`default_nettype none

module dtc_div
    import dtc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0]  rem_reg, rem_next, dvs_reg, dvs_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [DVS_W:0]    shifted;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/dtc_back.sv -----
// dtc_back: sequencer that turns one history's sums into slope, correlation and class
// depends on dtc_pkg, dtc_if, dtc_sqrt and dtc_div
`default_nettype none

module dtc_back
    import dtc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          job_valid,
    input  job_t          job,
    output logic          job_pop,
    dtc_result_if.source  res
);

    back_state_t state_reg, state_next;

    job_t                    job_reg;
    logic [SXY_W-1:0]        sxy_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [SQ_W-1:0]         nsdd_reg, sysq_reg;
    logic [SYY_W-1:0]        syy_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [LIM_W-1:0]        lim_reg;
    logic [OUT_W-1:0]        slope_reg, corr_reg;
    move_state_t             ms_reg;
    logic                    out_valid_reg;
    move_state_t             out_ms_reg;
    logic [OUT_W-1:0]        out_slope_reg, out_corr_reg;

    logic [SK_W-1:0]         sk;
    logic [SKK_W-1:0]        skk;
    logic [SXY_W-1:0]        nskd, sksy;
    logic [OUT_W-1:0]        corr_sat;
    logic [LIM_W-1:0]        lhs_mag;
    logic signed [OUT_W:0]   corr_s, ct_neg, ct_pos;
    logic                    syy_pos;

    logic                    div_start, div_done, sqrt_start, sqrt_done, load_out;
    logic [DVD_W-1:0]        div_dividend, quotient;
    logic [DVS_W-1:0]        div_divisor;
    logic [ROOT_W-1:0]       root;

    dtc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (prod_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    dtc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sk       = sk_of(job_reg.n);
    assign skk      = skk_of(job_reg.n);
    assign nskd     = job_reg.n * job_reg.sum_kd;
    assign sksy     = sk * job_reg.sum_d;
    assign syy_pos  = !syy_reg[SYY_W-1] && (syy_reg != '0);
    assign corr_sat = sat16(quotient, neg_reg);
    assign lhs_mag  = LIM_W'(num_reg) << SLOPE_SH;
    assign corr_s   = {corr_sat[OUT_W-1], corr_sat};
    assign ct_pos   = {2'b00, cfg.corr_thr};
    assign ct_neg   = -ct_pos;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (job_valid) state_next = B_MUL0;
            B_MUL0:  state_next = B_MUL1;
            B_MUL1:  state_next = B_MUL2;
            B_MUL2:
            begin
                if (job_reg.n < CNT_W'(3) || job_reg.gap == '0)
                    state_next = B_FIN;
                else
                    state_next = B_MUL3;
            end
            B_MUL3:  state_next = B_DIVS;
            B_DIVS:
            begin
                if (div_done)
                    state_next = syy_pos ? B_SQRT : B_FIN;
            end
            B_SQRT:
            begin
                if (sqrt_done)
                    state_next = (root == '0) ? B_FIN : B_DIVC;
            end
            B_DIVC:  if (div_done) state_next = B_FIN;
            B_FIN:   if (!out_valid_reg || res.ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job_pop      = 1'b0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        load_out     = 1'b0;
        div_dividend = DVD_W'(num_reg);
        div_divisor  = den_reg;
        unique case (state_reg)
            B_IDLE:  job_pop = job_valid;
            B_MUL3:  div_start = 1'b1;
            B_DIVS:  sqrt_start = div_done && syy_pos;
            B_SQRT:
            begin
                div_start    = sqrt_done && (root != '0);
                div_dividend = DVD_W'(mag_reg) << CORR_SH;
                div_divisor  = DVS_W'(root);
            end
            B_FIN:   load_out = !out_valid_reg || res.ready;
            default: ;
        endcase
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
                if (job_valid)
                    job_reg <= job;
            B_MUL0:
            begin
                sxy_reg  <= nskd - sksy;
                nsdd_reg <= SQ_W'(job_reg.n) * SQ_W'(job_reg.sum_dd);
            end
            B_MUL1:
            begin
                sysq_reg <= SQ_W'(job_reg.sum_d) * SQ_W'(job_reg.sum_d);
                neg_reg  <= sxy_reg[SXY_W-1];
                mag_reg  <= sxy_reg[SXY_W-1] ? MAG_W'(-sxy_reg) : MAG_W'(sxy_reg);
            end
            B_MUL2:
            begin
                syy_reg <= {1'b0, nsdd_reg} - {1'b0, sysq_reg};
                den_reg <= skk * job_reg.gap;
                num_reg <= mag_reg * cfg.frame_rate;
                if (job_reg.n < CNT_W'(3))
                begin
                    ms_reg    <= MS_NOT_ASSESSED;
                    slope_reg <= '0;
                    corr_reg  <= '0;
                end
                else
                begin
                    // zero time gap
                    ms_reg    <= MS_NOT_MOVE;
                    slope_reg <= SLOPE_ONE;
                    corr_reg  <= '0;
                end
            end
            B_MUL3:
            begin
                prod_reg <= PROD_W'(skk) * PROD_W'(syy_reg[SQ_W-1:0]);
                lim_reg  <= cfg.slope_thr * den_reg;
            end
            B_DIVS:
                if (div_done)
                begin
                    slope_reg <= corr_sat;
                    corr_reg  <= '0;
                    ms_reg    <= MS_NOT_MOVE;
                end
            B_DIVC:
                if (div_done)
                begin
                    corr_reg <= corr_sat;
                    if (neg_reg && lhs_mag > lim_reg && corr_s < ct_neg)
                        ms_reg <= MS_CLOSING;
                    else if (!neg_reg && lhs_mag > lim_reg && corr_s > ct_pos)
                        ms_reg <= MS_FAR_AWAY;
                    else
                        ms_reg <= MS_NOT_MOVE;
                end
            default: ;
        endcase
        if (load_out)
        begin
            out_ms_reg    <= ms_reg;
            out_slope_reg <= slope_reg;
            out_corr_reg  <= corr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.move_state  = out_ms_reg;
    assign res.slope       = out_slope_reg;
    assign res.correlation = out_corr_reg;

endmodule

`default_nettype wire

// ----- rtl/distance_trend_classifier.sv -----
// distance_trend_classifier: top level, register file and the front/queue/back chain
// depends on dtc_pkg, dtc_if, dtc_front, dtc_queue and dtc_back
//
// channel  dir  transaction                               handshake
// samp     in   distance, frame_num, last_sample         valid/ready
// res      out  move_state, slope, correlation           valid/ready
// cfg      in   index, data (register write)             valid/ready, ready tied high
//
// the front takes one sample per cycle; it stalls only when the history queue
// (two entries) is full and a sample arrives
// the back takes one history at a time: a pop state, four multiply states, the
// shared divider for slope, the square root, the divider again for correlation
// and a state that loads the output register once it is free
// short histories and a zero frame gap go from the multiplies straight to the load
// reset clears sums, queue, sequencer and output valid; registers take defaults
`default_nettype none

module distance_trend_classifier
    import dtc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dtc_sample_if.sink    samp,
    dtc_result_if.source  res,
    dtc_cfg_if.sink       cfg
);

    cfg_t  cfg_reg;
    logic  push, q_full, pop, pop_valid;
    job_t  push_job, pop_job;

    assign cfg.ready = 1'b1;

    // register writes; unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slope_thr  <= SLOPE_THR_RST;
            cfg_reg.corr_thr   <= CORR_THR_RST;
            cfg_reg.frame_rate <= FRAME_RATE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_SLOPE_THR:  cfg_reg.slope_thr  <= cfg.data;
                CFG_CORR_THR:   cfg_reg.corr_thr   <= cfg.data[CTHR_W-1:0];
                CFG_FRAME_RATE: cfg_reg.frame_rate <= cfg.data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // front: accumulates each history
    dtc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samp     (samp),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // decouples the sample rate from the per-history sequencer
    dtc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    // back: regression, correlation and classification
    dtc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .res       (res)
    );

endmodule

`default_nettype wire

// ----- rtl/dtc_checker.sv -----
// dtc_checker: port-level assertions for the distance trend classifier
// depends on dtc_pkg; bound to distance_trend_classifier below
`default_nettype none

module dtc_checker
    import dtc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [1:0]        res_move_state,
    input logic [OUT_W-1:0]  res_slope,
    input logic [OUT_W-1:0]  res_corr
);

    // a waiting result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_move_state)
            && $stable(res_slope) && $stable(res_corr))
        else $error("result changed while stalled");

    a_na_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_move_state == MS_NOT_ASSESSED |-> res_slope == '0 && res_corr == '0)
        else $error("not assessed with nonzero fields");

    a_closing: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_move_state == MS_CLOSING
            |-> res_corr[OUT_W-1] && (res_slope[OUT_W-1] || res_slope == '0))
        else $error("closing with non-negative trend");

    a_far: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_move_state == MS_FAR_AWAY
            |-> !res_corr[OUT_W-1] && res_corr != '0 && !res_slope[OUT_W-1])
        else $error("far away with non-positive trend");

endmodule

bind distance_trend_classifier dtc_checker u_dtc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_move_state (res.move_state),
    .res_slope      (res.slope),
    .res_corr       (res.correlation)
);

`default_nettype wire

// ----- dv/distance_trend_classifier_test.sv -----
// distance_trend_classifier_test: self-checking testbench for the distance trend classifier
// depends on dtc_pkg, dtc_if and the distance_trend_classifier rtl
// random sample histories against an internal predictor, with register phases and stalls

class trend_scoreboard;
    int unsigned slope_thr;
    int unsigned corr_thr;
    int unsigned rate;
    int unsigned cnt;
    longint unsigned sum_d, sum_kd, sum_dd;
    int unsigned first_frame, gap;
    logic [33:0] expected_results[$];
    int errors;
    int results_seen;

    function new();
        slope_thr = 1920;
        corr_thr = 21299;
        rate = 30;
        clear();
        errors = 0;
        results_seen = 0;
    endfunction

    function void clear();
        cnt = 0;
        sum_d = 0;
        sum_kd = 0;
        sum_dd = 0;
        first_frame = 0;
        gap = 0;
    endfunction

    function void add_expected(logic [33:0] e);
        expected_results.insert(expected_results.size(), e);
    endfunction

    function longint unsigned floor_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // note an accepted sample; queue a result when it closes a history
    function void note_sample(int unsigned d, int unsigned f, bit last);
        longint n, sk, skk, sxy, syy, sy, slope, corr, den, lhs, lim, ct;
        longint unsigned s;
        dtc_pkg::move_state_t st;
        if (cnt < dtc_pkg::MAX_SAMPLES)
        begin
            if (cnt == 0)
                first_frame = f;
            else if (cnt == 1)
                gap = (f - first_frame) & 16'hFFFF;
            sum_d += d;
            sum_kd += cnt * d;
            sum_dd += longint'(d) * d;
            cnt++;
        end
        if (!last)
            return;
        if (cnt < 3)
        begin
            add_expected({dtc_pkg::MS_NOT_ASSESSED, 16'd0, 16'd0});
            clear();
            return;
        end
        n = cnt;
        sk = n * (n - 1) / 2;
        skk = n * ((n - 1) * n * (2 * n - 1) / 6) - sk * sk;
        sy = sum_d;
        sxy = n * longint'(sum_kd) - sk * sy;
        syy = n * longint'(sum_dd) - sy * sy;
        st = dtc_pkg::MS_NOT_MOVE;
        corr = 0;
        if (gap == 0)
            slope = 256;
        else
        begin
            den = skk * longint'(gap);
            lhs = 256 * sxy * longint'(rate);
            lim = longint'(slope_thr) * den;
            slope = clamp16((sxy * longint'(rate)) / den);
            if (syy > 0)
            begin
                s = floor_root(longint'(skk) * syy);
                ct = corr_thr;
                if (s != 0)
                begin
                    corr = clamp16((sxy * 32768) / longint'(s));
                    if (lhs < -lim && corr < -ct)
                        st = dtc_pkg::MS_CLOSING;
                    else if (lhs > lim && corr > ct)
                        st = dtc_pkg::MS_FAR_AWAY;
                end
            end
        end
        add_expected({st, slope[15:0], corr[15:0]});
        clear();
    endfunction

    task check_result(logic [1:0] ms, logic [15:0] sl, logic [15:0] co);
        logic [33:0] e;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report("unexpected result", 0, 0);
            return;
        end
        e = expected_results.pop_front();
        if (ms !== e[33:32])
            report("move_state", e[33:32], ms);
        if (sl !== e[31:16])
            report("slope", e[31:16], sl);
        if (co !== e[15:0])
            report("correlation", e[15:0], co);
    endtask

    task report(string what, int unsigned exp_v, int unsigned got_v);
        errors++;
        if (errors <= 30)
            $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
    endtask
endclass

module distance_trend_classifier_test;
    import dtc_pkg::*;

    logic clk;
    logic rst_n;
    int unsigned idle_cycles;
    bit stalls_on;
    bit timed_out;
    int unsigned samples_sent;
    int unsigned histories_sent;

    dtc_sample_if samp ();
    dtc_result_if res ();
    dtc_cfg_if cfg ();

    trend_scoreboard board;

    distance_trend_classifier uut (
        .clk  (clk),
        .rst_n(rst_n),
        .samp (samp),
        .res  (res),
        .cfg  (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // monitor: note inputs, check results, count idle cycles for the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samp.valid && samp.ready)
                board.note_sample(samp.distance, samp.frame_num, samp.last_sample);
            if (res.valid && res.ready)
                board.check_result(res.move_state, res.slope, res.correlation);
            if ((samp.valid && samp.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000 && !timed_out)
            begin
                timed_out = 1'b1;
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("distance_trend_classifier_test: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall bursts on ready while stalls are enabled
    initial
    begin
        int unsigned k;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                res.ready <= 1'b0;
                k = $urandom_range(1, 15);
                repeat (k) @(posedge clk);
            end
            else
            begin
                res.ready <= 1'b1;
                k = $urandom_range(1, 20);
                repeat (k) @(posedge clk);
            end
        end
    end

    // one sample transaction, with an optional gap before it
    // valid stays high after acceptance; the next sample or an idle step replaces it
    task automatic send_sample(input logic [15:0] d, input logic [15:0] f, input bit last);
        if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            samp.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        samp.valid <= 1'b1;
        samp.distance <= d;
        samp.frame_num <= f;
        samp.last_sample <= last;
        @(posedge clk);
        while (!samp.ready)
            @(posedge clk);
        samples_sent++;
        if (last)
            histories_sent++;
    endtask

    // a history of n samples: trend plus noise, frame step may be zero or wrap
    task automatic send_history(input int n, input int unsigned step, input int unsigned start,
                                input int unsigned base, input int trend, input int unsigned noise);
        int i;
        int v;
        logic [15:0] f;
        f = 16'(start);
        for (i = 0; i < n; i++)
        begin
            v = int'(base) + trend * i + int'($urandom_range(0, noise));
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            send_sample(v[15:0], f, i == n - 1);
            f = f + step[15:0];
        end
    endtask

    // write a register only when the block is drained
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        samp.valid <= 1'b0;
        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_SLOPE_THR:  board.slope_thr = value;
            CFG_CORR_THR:   board.corr_thr = value[14:0];
            CFG_FRAME_RATE: board.rate = value[7:0];
            default:        ;
        endcase
    endtask

    task automatic random_histories(input int count);
        int h;
        int n;
        int unsigned pick;
        for (h = 0; h < count; h++)
        begin
            pick = $urandom_range(0, 19);
            n = (pick == 0) ? $urandom_range(1, 2) :
                (pick == 1) ? $urandom_range(11, 15) : $urandom_range(3, 10);
            if (pick == 2)
                send_history(n, $urandom_range(0, 65535), $urandom, $urandom_range(0, 65535),
                             0, 65535);
            else
                send_history(n, (pick == 3) ? 0 : $urandom_range(1, 4),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             int'($urandom_range(0, 1200)) - 600, $urandom_range(0, 300));
        end
    endtask

    initial
    begin
        board = new();
        idle_cycles = 0;
        stalls_on = 1'b0;
        timed_out = 1'b0;
        samples_sent = 0;
        histories_sent = 0;
        samp.valid <= 1'b0;
        samp.distance <= '0;
        samp.frame_num <= '0;
        samp.last_sample <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_SLOPE_THR;
        cfg.data <= '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short histories, extremes, zero gap, wrap, constant, overlong
        send_history(1, 1, 0, 0, 0, 0);
        send_history(2, 1, 65535, 65535, 0, 0);
        send_history(3, 1, 0, 0, 0, 0);
        send_history(3, 1, 100, 65535, -30000, 0);
        send_history(3, 0, 7, 1000, 50, 0);
        send_history(4, 3, 65534, 100, 200, 0);
        send_history(5, 1, 10, 2000, 0, 0);
        send_history(14, 1, 0, 65535, -2000, 0);
        send_history(15, 1, 0, 0, 4000, 0);

        // phases of register settings, extremes included
        write_reg(CFG_SLOPE_THR, 16'd0);
        write_reg(CFG_CORR_THR, 16'd0);
        write_reg(CFG_FRAME_RATE, 16'd255);
        stalls_on = 1'b1;
        random_histories(40);
        write_reg(CFG_SLOPE_THR, 16'hFFFF);
        write_reg(CFG_CORR_THR, 16'h7FFF);
        write_reg(CFG_FRAME_RATE, 16'd1);
        random_histories(40);
        write_reg(CFG_FRAME_RATE, 16'd0);
        random_histories(15);
        write_reg(CFG_SLOPE_THR, 16'($urandom_range(0, 3000)));
        write_reg(CFG_CORR_THR, 16'($urandom_range(0, 32767)));
        write_reg(CFG_FRAME_RATE, 16'($urandom_range(1, 255)));
        random_histories(40);
        write_reg(CFG_SLOPE_THR, 16'd1920);
        write_reg(CFG_CORR_THR, 16'd21299);
        write_reg(CFG_FRAME_RATE, 16'd30);
        random_histories(30);
        // last part runs without idling
        stalls_on = 1'b0;
        random_histories(25);
        samp.valid <= 1'b0;

        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("covered %0d samples in %0d histories, %0d results checked",
                 samples_sent, histories_sent, board.results_seen);
        if (board.errors == 0)
            $display("distance_trend_classifier_test: PASS");
        else
            $display("distance_trend_classifier_test: FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/dtc_pkg.sv
rtl/dtc_if.sv
rtl/dtc_front.sv
rtl/dtc_queue.sv
rtl/dtc_sqrt.sv
rtl/dtc_div.sv
rtl/dtc_back.sv
rtl/distance_trend_classifier.sv
rtl/dtc_checker.sv
dv/distance_trend_classifier_test.sv
